>>> src/ocb_pkg.sv
// Shared constants, types and codes of the octant centre-of-mass binner.
package ocb_pkg;

    localparam int CELL_CAPACITY = 256;
    localparam int BRANCHING     = 8;
    localparam int NCELLS        = BRANCHING * BRANCHING;
    localparam int SUB_W         = $clog2(BRANCHING);
    localparam int CELL_W        = $clog2(NCELLS);

    localparam int POS_W     = 24;
    localparam int MASS_W    = 24;
    localparam int CNT_W     = 9;
    localparam int SUM_W     = 32;
    localparam int MOM_W     = 56;
    localparam int QCNT_W    = 12;
    localparam int QMASS_W   = 35;
    localparam int QMOM_W    = 59;
    localparam int PMARK_W   = 23;
    localparam int CFG_W     = 24;
    localparam int DIV_STEPS = QMOM_W;
    localparam int DIVC_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SPARE = 2'd3
    } status_t;

    typedef enum logic {
        CFG_POS_MARK = 1'b0,
        CFG_NEG_MARK = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_RD,
        S_Q_ACC,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] mass;
        logic [MOM_W-1:0] mx;
        logic [MOM_W-1:0] my;
        logic [MOM_W-1:0] mz;
    } cell_t;

    typedef struct packed {
        logic take_in;
        logic add_rd;
        logic add_wr;
        logic q_rd;
        logic q_acc;
        logic div_start;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       q_last;
        logic       div_done;
    } dp_sts_t;

endpackage

>>> src/ocb_if.sv
// Item channels: request carrying one body or query, response carrying one result.
interface ocb_req_if;
    import ocb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [MASS_W-1:0]        body_mass;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [CELL_W-1:0]        query_index;
    logic                     query_level;
    modport source (output valid, mode, body_mass, pos_x, pos_y, pos_z, query_index,
                     query_level, input ready);
    modport sink (input valid, mode, body_mass, pos_x, pos_y, pos_z, query_index,
                   query_level, output ready);
endinterface

interface ocb_rsp_if;
    import ocb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [CELL_W-1:0]        cell_res;
    logic [QCNT_W-1:0]        body_count;
    logic [QMASS_W-1:0]       total_mass;
    logic signed [POS_W-1:0]  center_x;
    logic signed [POS_W-1:0]  center_y;
    logic signed [POS_W-1:0]  center_z;
    modport source (output valid, status, cell_res, body_count, total_mass, center_x,
                     center_y, center_z, input ready);
    modport sink (input valid, status, cell_res, body_count, total_mass, center_x,
                   center_y, center_z, output ready);
endinterface

>>> src/ocb_div.sv
// Bit-serial restoring divider: low quotient bits of a 59-bit magnitude by a 35-bit mass.
module ocb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ocb_pkg::QMOM_W-1:0]   dividend,
    input  logic [ocb_pkg::QMASS_W-1:0]  divisor,
    output logic [ocb_pkg::POS_W-1:0]    quo,
    output logic                         done
);
    import ocb_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIVC_W-1:0]   cnt_reg, cnt_next;
    logic [QMASS_W-1:0]  rem_reg, rem_next;
    logic [QMOM_W-1:0]   dvd_reg, dvd_next;
    logic [POS_W-1:0]    quo_reg, quo_next;
    logic [QMASS_W:0]    shifted;
    logic [QMASS_W:0]    trial;
    logic                qbit;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[QMOM_W-1]};
        trial     = shifted - {1'b0, divisor};
        qbit      = (shifted >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVC_W'(DIV_STEPS - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? trial[QMASS_W-1:0] : shifted[QMASS_W-1:0];
            dvd_next = {dvd_reg[QMOM_W-2:0], 1'b0};
            quo_next = {quo_reg[POS_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

>>> src/ocb_ctrl.sv
// Sequencing state machine of the binner.
module ocb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ocb_pkg::dp_sts_t  sts,
    output ocb_pkg::dp_cmd_t  cmd
);
    import ocb_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (sts.in_mode)
                        MODE_ADD:   state_next = S_ADD_RD;
                        MODE_QUERY: state_next = S_Q_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ADD_RD:    state_next = S_ADD_WR;
            S_ADD_WR:    state_next = S_DONE;
            S_Q_RD:      state_next = S_Q_ACC;
            S_Q_ACC:     state_next = sts.q_last ? S_DIV_START : S_Q_RD;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  state_next = sts.div_done ? S_DONE : S_DIV_WAIT;
            S_DONE:      state_next = slot_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            S_ADD_RD:    cmd.add_rd    = 1'b1;
            S_ADD_WR:    cmd.add_wr    = 1'b1;
            S_Q_RD:      cmd.q_rd      = 1'b1;
            S_Q_ACC:     cmd.q_acc     = 1'b1;
            S_DIV_START: cmd.div_start = 1'b1;
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken one");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_wr |-> $past(cmd.add_rd))
        else $error("cell write without its read");
    a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && sts.div_done) |=> state_reg == S_DONE)
        else $error("division finish missed");
    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_in |=> !in_ready)
        else $error("second item taken while busy");

endmodule

>>> src/ocb_dp.sv
// Datapath: placement, cell store, accumulation, dividers and result registers.
module ocb_dp (
    input  logic              clk,
    input  logic              rst_n,
    ocb_req_if.sink           req,
    ocb_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [ocb_pkg::CFG_W-1:0] cfg_data,
    input  ocb_pkg::dp_cmd_t  cmd,
    output ocb_pkg::dp_sts_t  sts
);
    import ocb_pkg::*;

    // configuration
    logic [PMARK_W-1:0]       pmark_reg;
    logic signed [POS_W-1:0]  nmark_reg;

    // latched item
    logic [MASS_W-1:0]        mass_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic [CELL_W-1:0]        cell_reg;
    logic [CELL_W-1:0]        qidx_reg;
    logic                     qlvl_reg;
    logic [SUB_W-1:0]         k_reg;

    // store
    cell_t                    mem [NCELLS];
    logic [NCELLS-1:0]        vld_reg;
    cell_t                    rd_reg;
    logic                     rd_vld_reg;
    logic [CELL_W-1:0]        rd_addr;
    cell_t                    cur;

    // products
    logic signed [POS_W+MASS_W:0] prx_reg, pry_reg, prz_reg;

    // accumulators
    logic [QCNT_W-1:0]        acnt_reg;
    logic [QMASS_W-1:0]       amass_reg;
    logic signed [QMOM_W-1:0] amx_reg, amy_reg, amz_reg;

    // results
    logic [1:0]               r_st_reg, o_st_reg;
    logic [CELL_W-1:0]        r_cell_reg, o_cell_reg;
    logic [QCNT_W-1:0]        r_cnt_reg, o_cnt_reg;
    logic [QMASS_W-1:0]       r_mass_reg, o_mass_reg;
    logic [POS_W-1:0]         r_cx_reg, r_cy_reg, r_cz_reg;
    logic [POS_W-1:0]         o_cx_reg, o_cy_reg, o_cz_reg;

    // placement
    logic [SUB_W-1:0]         oct, sub;
    logic signed [POS_W-1:0]  pmark_s;

    // dividers
    logic [QMOM_W-1:0]        magx, magy, magz;
    logic [POS_W-1:0]         qx, qy, qz;
    logic                     dx, dy, dz;
    logic                     cen_ok;

    cell_t                    new_cell;
    logic                     full;
    logic [CELL_W-1:0]        res_idx;

    assign pmark_s = $signed({1'b0, pmark_reg});

    always_comb
    begin
        oct    = '0;
        sub    = '0;
        oct[0] = !req.pos_x[POS_W-1];
        oct[1] = !req.pos_y[POS_W-1];
        oct[2] = !req.pos_z[POS_W-1];
        sub[0] = req.pos_x >= (oct[0] ? pmark_s : nmark_reg);
        sub[1] = req.pos_y >= (oct[1] ? pmark_s : nmark_reg);
        sub[2] = req.pos_z >= (oct[2] ? pmark_s : nmark_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmark_reg <= PMARK_W'(4096);
            nmark_reg <= -POS_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POS_MARK: pmark_reg <= cfg_data[PMARK_W-1:0];
                CFG_NEG_MARK: nmark_reg <= $signed(cfg_data[POS_W-1:0]);
                default: ;
            endcase
        end
    end

    assign res_idx = qlvl_reg ? {{(CELL_W-SUB_W){1'b0}}, qidx_reg[SUB_W-1:0]} : qidx_reg;
    assign rd_addr = cmd.q_rd ? (qlvl_reg ? {qidx_reg[SUB_W-1:0], k_reg} : qidx_reg)
                              : cell_reg;
    assign cur     = rd_vld_reg ? rd_reg : '0;
    assign full    = cur.cnt >= CNT_W'(CELL_CAPACITY);

    always_comb
    begin
        new_cell      = cur;
        new_cell.cnt  = cur.cnt + 1'b1;
        new_cell.mass = cur.mass + SUM_W'(mass_reg);
        new_cell.mx   = cur.mx + MOM_W'(prx_reg);
        new_cell.my   = cur.my + MOM_W'(pry_reg);
        new_cell.mz   = cur.mz + MOM_W'(prz_reg);
    end

    // store: payload array, valid flags cleared by reset or a clear item
    always_ff @(posedge clk)
    begin
        if (cmd.add_rd || cmd.q_rd)
            rd_reg <= mem[rd_addr];
        if (cmd.add_wr && !full)
            mem[cell_reg] <= new_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            if (cmd.add_rd || cmd.q_rd)
                rd_vld_reg <= vld_reg[rd_addr];
            if (cmd.add_wr && !full)
                vld_reg[cell_reg] <= 1'b1;
            if (cmd.take_in && mode_t'(req.mode) == MODE_CLEAR)
                vld_reg <= '0;
            if (cmd.take_in)
                k_reg <= '0;
            else if (cmd.q_acc)
                k_reg <= k_reg + 1'b1;
        end
    end

    assign magx = amx_reg[QMOM_W-1] ? QMOM_W'(-amx_reg) : amx_reg;
    assign magy = amy_reg[QMOM_W-1] ? QMOM_W'(-amy_reg) : amy_reg;
    assign magz = amz_reg[QMOM_W-1] ? QMOM_W'(-amz_reg) : amz_reg;

    ocb_div u_div_x (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(magx),
                     .divisor(amass_reg), .quo(qx), .done(dx));
    ocb_div u_div_y (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(magy),
                     .divisor(amass_reg), .quo(qy), .done(dy));
    ocb_div u_div_z (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(magz),
                     .divisor(amass_reg), .quo(qz), .done(dz));

    assign cen_ok = (acnt_reg != '0) && (amass_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            mass_reg  <= req.body_mass;
            px_reg    <= req.pos_x;
            py_reg    <= req.pos_y;
            pz_reg    <= req.pos_z;
            cell_reg  <= {oct, sub};
            qidx_reg  <= req.query_index;
            qlvl_reg  <= req.query_level;
            acnt_reg  <= '0;
            amass_reg <= '0;
            amx_reg   <= '0;
            amy_reg   <= '0;
            amz_reg   <= '0;
            r_st_reg   <= ST_OK;
            r_cell_reg <= '0;
            r_cnt_reg  <= '0;
            r_mass_reg <= '0;
            r_cx_reg   <= '0;
            r_cy_reg   <= '0;
            r_cz_reg   <= '0;
        end
        if (cmd.add_rd)
        begin
            prx_reg <= $signed({1'b0, mass_reg}) * px_reg;
            pry_reg <= $signed({1'b0, mass_reg}) * py_reg;
            prz_reg <= $signed({1'b0, mass_reg}) * pz_reg;
        end
        if (cmd.add_wr)
        begin
            r_st_reg   <= full ? ST_FULL : ST_OK;
            r_cell_reg <= cell_reg;
            r_cnt_reg  <= QCNT_W'(full ? cur.cnt : new_cell.cnt);
            r_mass_reg <= QMASS_W'(full ? cur.mass : new_cell.mass);
        end
        if (cmd.q_acc)
        begin
            acnt_reg  <= acnt_reg + QCNT_W'(cur.cnt);
            amass_reg <= amass_reg + QMASS_W'(cur.mass);
            amx_reg   <= amx_reg + QMOM_W'($signed(cur.mx));
            amy_reg   <= amy_reg + QMOM_W'($signed(cur.my));
            amz_reg   <= amz_reg + QMOM_W'($signed(cur.mz));
        end
        if (dx)
        begin
            r_st_reg   <= (acnt_reg == '0) ? ST_EMPTY : ST_OK;
            r_cell_reg <= res_idx;
            r_cnt_reg  <= acnt_reg;
            r_mass_reg <= amass_reg;
            r_cx_reg   <= !cen_ok ? '0 : (amx_reg[QMOM_W-1] ? -qx : qx);
            r_cy_reg   <= !cen_ok ? '0 : (amy_reg[QMOM_W-1] ? -qy : qy);
            r_cz_reg   <= !cen_ok ? '0 : (amz_reg[QMOM_W-1] ? -qz : qz);
        end
        if (cmd.load_out)
        begin
            o_st_reg   <= r_st_reg;
            o_cell_reg <= r_cell_reg;
            o_cnt_reg  <= r_cnt_reg;
            o_mass_reg <= r_mass_reg;
            o_cx_reg   <= r_cx_reg;
            o_cy_reg   <= r_cy_reg;
            o_cz_reg   <= r_cz_reg;
        end
    end

    assign sts.in_mode  = req.mode;
    assign sts.q_last   = !qlvl_reg || (k_reg == SUB_W'(BRANCHING - 1));
    assign sts.div_done = dx && dy && dz;

    assign rsp.status     = o_st_reg;
    assign rsp.cell_res   = o_cell_reg;
    assign rsp.body_count = o_cnt_reg;
    assign rsp.total_mass = o_mass_reg;
    assign rsp.center_x   = o_cx_reg;
    assign rsp.center_y   = o_cy_reg;
    assign rsp.center_z   = o_cz_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_in && req.mode == MODE_CLEAR) |=> vld_reg == '0)
        else $error("clear left a valid cell");
    a_dividers_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx == dy && dy == dz)
        else $error("dividers out of step");
    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add_wr && full) |=> $stable(vld_reg))
        else $error("refused body changed the store");

endmodule

>>> src/octant_center_of_mass_binner_top.sv
// Top level of the two-level octree centre-of-mass binner.
//
//  channel  dir  handshake          carries
//  req      in   req.valid/ready    mode, body_mass, pos_x/y/z, query_index, query_level
//  rsp      out  rsp.valid/ready    status, cell_res, body_count, total_mass, center_x/y/z
//  cfg      in   cfg_we             cfg_index (0 pos mark, 1 neg mark), cfg_data
//
// Add item: take, cell read, read-modify-write, result. Leaf query: reads and accumulates
// one cell; octant query: its eight cells in turn; both then run the 59-step serial
// dividers for the three centre coordinates. Clear and unused-mode items go from take
// straight to the result. Reset empties the store at once via valid flags.
// A finished result sits in the output register while the next item is taken;
// the machine only waits in its done state if that register is still occupied.
module octant_center_of_mass_binner_top (
    input  logic                       clk,
    input  logic                       rst_n,
    ocb_req_if.sink                    req,
    ocb_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ocb_pkg::CFG_W-1:0]  cfg_data
);
    import ocb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: owns both handshakes' control side
    ocb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: store, arithmetic and result payload
    ocb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the octant centre-of-mass binner: random and directed items.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ocb_pkg::*;

    // one request item as the driver sees it
    typedef struct packed {
        mode_t             mode;
        logic [23:0]       mass;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [5:0]        qidx;
        logic              qlvl;
    } body_item_t;

    // one result item, field for field as on the response channel
    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         cell_res;
        logic [11:0]        cnt;
        logic [34:0]        mass;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
    } bin_result_t;

    localparam int IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ocb_req_if req_ch();
    ocb_rsp_if rsp_ch();

    octant_center_of_mass_binner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // free-running clock, 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the binner: marks and the 64-cell store
    // ---------------------------------------------------------------
    logic [22:0]        pos_mark;
    logic signed [23:0] neg_mark;
    logic [8:0]         shadow_cnt  [NCELLS];
    logic [31:0]        shadow_mass [NCELLS];
    longint             shadow_mx   [NCELLS];
    longint             shadow_my   [NCELLS];
    longint             shadow_mz   [NCELLS];

    body_item_t  pending_items[$];
    bin_result_t expected_results[$];

    int errors;
    int n_adds, n_refused, n_queries, n_empty, n_clears, n_results;
    bit quiet;          // no idling on either side when set

    function automatic void wipe_store();
        for (int c = 0; c < NCELLS; c++)
        begin
            shadow_cnt[c]  = '0;
            shadow_mass[c] = '0;
            shadow_mx[c]   = 0;
            shadow_my[c]   = 0;
            shadow_mz[c]   = 0;
        end
    endfunction

    // sign picks the octant bit, the mark on that side picks the subcell bit
    function automatic void place_axis(input int c, input int bitval,
                                       inout int oct, inout int sub);
        int mark;
        if (c >= 0)
        begin
            oct  = oct | bitval;
            mark = int'(pos_mark);
        end
        else
            mark = int'(neg_mark);
        if (c >= mark)
            sub = sub | bitval;
    endfunction

    // moment / mass, truncated toward zero, kept to 24 bits
    function automatic logic [23:0] centre_of(input longint mom, input longint unsigned m);
        longint unsigned mag, q;
        if (m == 0)
            return '0;
        mag = (mom < 0) ? longint'(-mom) : longint'(mom);
        q   = mag / m;
        if (mom < 0)
            q = -q;
        return q[23:0];
    endfunction

    function automatic void bin_item(input body_item_t it);
        bin_result_t r;
        int oct, sub, cell_no, cnt, first, n;
        longint unsigned msum;
        longint mx, my, mz, m;
        r = '0;
        case (it.mode)
            MODE_ADD:
            begin
                oct = 0;
                sub = 0;
                place_axis(int'(it.x), 1, oct, sub);
                place_axis(int'(it.y), 2, oct, sub);
                place_axis(int'(it.z), 4, oct, sub);
                cell_no = (oct * BRANCHING + sub) % NCELLS;
                n_adds++;
                if (shadow_cnt[cell_no] >= CELL_CAPACITY)
                begin
                    r.status = ST_FULL;
                    n_refused++;
                end
                else
                begin
                    m = longint'({40'd0, it.mass});
                    shadow_cnt[cell_no]  = shadow_cnt[cell_no] + 1;
                    shadow_mass[cell_no] = shadow_mass[cell_no] + 32'(it.mass);
                    shadow_mx[cell_no]   = shadow_mx[cell_no] + longint'(it.x) * m;
                    shadow_my[cell_no]   = shadow_my[cell_no] + longint'(it.y) * m;
                    shadow_mz[cell_no]   = shadow_mz[cell_no] + longint'(it.z) * m;
                end
                r.cell_res = 6'(cell_no);
                r.cnt      = 12'(shadow_cnt[cell_no]);
                r.mass     = 35'(shadow_mass[cell_no]);
            end
            MODE_QUERY:
            begin
                n_queries++;
                if (it.qlvl)
                begin
                    r.cell_res = {3'b000, it.qidx[2:0]};
                    first      = int'(it.qidx[2:0]) * BRANCHING;
                    n          = BRANCHING;
                end
                else
                begin
                    r.cell_res = it.qidx;
                    first      = int'(it.qidx);
                    n          = 1;
                end
                cnt  = 0;
                msum = 0;
                mx   = 0;
                my   = 0;
                mz   = 0;
                for (int k = 0; k < n; k++)
                begin
                    cnt  += int'(shadow_cnt[(first + k) % NCELLS]);
                    msum += shadow_mass[(first + k) % NCELLS];
                    mx   += shadow_mx[(first + k) % NCELLS];
                    my   += shadow_my[(first + k) % NCELLS];
                    mz   += shadow_mz[(first + k) % NCELLS];
                end
                r.status = (cnt == 0) ? ST_EMPTY : ST_OK;
                r.cnt    = 12'(cnt);
                r.mass   = msum[34:0];
                if (cnt != 0)
                begin
                    r.cx = centre_of(mx, msum);
                    r.cy = centre_of(my, msum);
                    r.cz = centre_of(mz, msum);
                end
                else
                    n_empty++;
            end
            MODE_CLEAR:
            begin
                wipe_store();
                n_clears++;
            end
            default: ;  // unused mode: all-zero result, store untouched
        endcase
        expected_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // Driver: feeds the request channel from pending_items
    // ---------------------------------------------------------------
    body_item_t cur_item;
    int         req_gap;

    always @(posedge clk)
    begin
        logic       take;
        logic       nxt_valid;
        body_item_t nxt;
        if (rst_n)
        begin
            take      = req_ch.valid && req_ch.ready;
            nxt_valid = req_ch.valid && !take;
            if (take)
                bin_item(cur_item);
            if (!nxt_valid)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (pending_items.size() > 0)
                begin
                    nxt      = pending_items.pop_front();
                    cur_item = nxt;
                    nxt_valid = 1'b1;
                    req_ch.mode        <= nxt.mode;
                    req_ch.body_mass   <= nxt.mass;
                    req_ch.pos_x       <= nxt.x;
                    req_ch.pos_y       <= nxt.y;
                    req_ch.pos_z       <= nxt.z;
                    req_ch.query_index <= nxt.qidx;
                    req_ch.query_level <= nxt.qlvl;
                    // burst of idle cycles after this item, now and then
                    if (!quiet && $urandom_range(0, 4) == 0)
                        req_gap = $urandom_range(1, 5);
                end
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result against the oldest expectation
    // ---------------------------------------------------------------
    int rsp_stall;

    always @(posedge clk)
    begin
        bin_result_t e;
        logic        nxt_ready;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: status=%0d cell=%0d",
                             $time, rsp_ch.status, rsp_ch.cell_res);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (rsp_ch.status !== e.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, rsp_ch.status);
                    end
                    if (rsp_ch.cell_res !== e.cell_res)
                    begin
                        errors++;
                        $display("%0t: cell_res expected %0d actual %0d",
                                 $time, e.cell_res, rsp_ch.cell_res);
                    end
                    if (rsp_ch.body_count !== e.cnt)
                    begin
                        errors++;
                        $display("%0t: body_count expected %0d actual %0d",
                                 $time, e.cnt, rsp_ch.body_count);
                    end
                    if (rsp_ch.total_mass !== e.mass)
                    begin
                        errors++;
                        $display("%0t: total_mass expected %0d actual %0d",
                                 $time, e.mass, rsp_ch.total_mass);
                    end
                    if (rsp_ch.center_x !== e.cx)
                    begin
                        errors++;
                        $display("%0t: center_x expected %0d actual %0d",
                                 $time, e.cx, rsp_ch.center_x);
                    end
                    if (rsp_ch.center_y !== e.cy)
                    begin
                        errors++;
                        $display("%0t: center_y expected %0d actual %0d",
                                 $time, e.cy, rsp_ch.center_y);
                    end
                    if (rsp_ch.center_z !== e.cz)
                    begin
                        errors++;
                        $display("%0t: center_z expected %0d actual %0d",
                                 $time, e.cz, rsp_ch.center_z);
                    end
                end
            end
            // back-pressure in bursts
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                nxt_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_stall = $urandom_range(0, 4);
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            rsp_ch.ready <= nxt_ready;
        end
    end

    // watchdog: cycles with no item moving on either channel
    int idle_cycles;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // positions biased towards the extremes and both marks
    function automatic logic signed [23:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sd0;
            3: return -24'sd1;
            4: return 24'($signed({1'b0, pos_mark}) + $signed(3'($urandom_range(0, 4))) - 2);
            5: return 24'(neg_mark + $signed(4'($urandom_range(0, 4))) - 2);
            6: return 24'($urandom_range(0, 16383)) - 24'sd8192;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_mass();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1, 64));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_body(input logic [23:0] m, input logic signed [23:0] x,
                            input logic signed [23:0] y, input logic signed [23:0] z);
        body_item_t it;
        it      = body_item_t'($urandom);  // unused fields random too
        it.mode = MODE_ADD;
        it.mass = m;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        pending_items.push_back(it);
    endtask

    task automatic ask_cell(input logic [5:0] idx, input logic lvl);
        body_item_t it;
        it.mass = pick_mass();
        it.x    = 24'($urandom);
        it.y    = 24'($urandom);
        it.z    = 24'($urandom);
        it.mode = MODE_QUERY;
        it.qidx = idx;
        it.qlvl = lvl;
        pending_items.push_back(it);
    endtask

    task automatic plain_item(input mode_t md);
        body_item_t it;
        it.mass = pick_mass();
        it.x    = pick_pos();
        it.y    = pick_pos();
        it.z    = pick_pos();
        it.qidx = 6'($urandom);
        it.qlvl = 1'($urandom);
        it.mode = md;
        pending_items.push_back(it);
    endtask

    // mostly adds, a steady share of queries, rare clears and spare-mode items
    task automatic random_items(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                add_body(pick_mass(), pick_pos(), pick_pos(), pick_pos());
            else if (sel < 95)
                ask_cell(6'($urandom), 1'($urandom));
            else if (sel < 97)
                plain_item(MODE_CLEAR);
            else
                plain_item(MODE_NONE);
        end
    endtask

    // wait for the block to drain, then let its longest latency pass
    task automatic settle();
        while (pending_items.size() > 0 || req_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_mark(input cfg_idx_t idx, input logic [23:0] d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        if (idx == CFG_POS_MARK)
            pos_mark = d[22:0];
        else
            neg_mark = d;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic signed [23:0] fx, fy, fz;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POS_MARK;
        cfg_data  = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_ADD;
        req_ch.body_mass   = '0;
        req_ch.pos_x       = '0;
        req_ch.pos_y       = '0;
        req_ch.pos_z       = '0;
        req_ch.query_index = '0;
        req_ch.query_level = 1'b0;
        rsp_ch.ready       = 1'b0;
        errors = 0;
        n_adds = 0; n_refused = 0; n_queries = 0; n_empty = 0; n_clears = 0; n_results = 0;
        quiet = 1'b0;
        req_gap = 0;
        rsp_stall = 0;
        pos_mark = 23'd4096;
        neg_mark = -24'sd4096;
        wipe_store();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty queries, field extremes, marks exactly, zero mass, spare mode
        ask_cell(6'd0, 1'b0);
        ask_cell(6'd63, 1'b1);                      // octant index wraps to 7
        add_body(24'hFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        add_body(24'hFFFFFF, 24'sh800000, 24'sh800000, 24'sh800000);
        add_body(24'd1, 24'sd4096, 24'sd4095, 24'sd0);
        add_body(24'd7, -24'sd4096, -24'sd4097, -24'sd1);
        add_body(24'd0, 24'sd100, -24'sd100, 24'sd5000);  // mass-less body
        ask_cell(6'd63, 1'b0);
        ask_cell(6'd0, 1'b0);
        ask_cell(6'd7, 1'b1);
        ask_cell(6'd0, 1'b1);
        ask_cell(6'd5, 1'b1);
        plain_item(MODE_NONE);
        add_body(24'd0, 24'sd4096, 24'sd4096, 24'sd4096);
        ask_cell(6'd63, 1'b0);
        plain_item(MODE_CLEAR);
        ask_cell(6'd63, 1'b0);
        ask_cell(6'd7, 1'b1);
        random_items(480);
        settle();

        // marks at zero; the top data bit is ignored for the positive mark
        write_mark(CFG_POS_MARK, {1'b1, 23'd0});
        write_mark(CFG_NEG_MARK, 24'd0);
        random_items(300);
        settle();

        // marks at their extremes
        write_mark(CFG_POS_MARK, {1'($urandom), 23'h7FFFFF});
        write_mark(CFG_NEG_MARK, 24'h800000);
        random_items(300);
        settle();

        // random marks, then push one cell past its capacity with heavy bodies
        write_mark(CFG_POS_MARK, 24'($urandom));
        write_mark(CFG_NEG_MARK, 24'($urandom));
        plain_item(MODE_CLEAR);
        fx = pick_pos();
        fy = pick_pos();
        fz = pick_pos();
        for (int i = 0; i < 262; i++)
            add_body(($urandom_range(0, 3) == 0) ? pick_mass() : 24'hFFFFFF, fx, fy, fz);
        for (int q = 0; q < 64; q++)
            ask_cell(6'(q), 1'b0);
        for (int q = 0; q < 8; q++)
            ask_cell(6'(q + 8 * $urandom_range(0, 7)), 1'b1);
        random_items(100);
        settle();

        // final stretch without idling on either side
        quiet = 1'b1;
        random_items(200);
        settle();

        $display("covered %0d adds (%0d refused as full), %0d queries (%0d empty), %0d clears",
                 n_adds, n_refused, n_queries, n_empty, n_clears);
        $display("%0d results checked under four mark settings, %0d mismatches",
                 n_results, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
src/ocb_pkg.sv
src/ocb_if.sv
src/ocb_div.sv
src/ocb_ctrl.sv
src/ocb_dp.sv
src/octant_center_of_mass_binner_top.sv
tb/sv/testbench.sv
